>>> hdl/udd_pkg.sv
`timescale 1ns / 1ps
// Package for the undirected edge duplicate detector.
// Holds action codes, result widths and the command and response types of the hash set.
package udd_pkg;

    localparam int EDGE_NUM_BITS = 16;
    localparam logic [EDGE_NUM_BITS-1:0] EDGE_NUM_MAX = '1;

    localparam logic ACT_CHECK = 1'b0;
    localparam logic ACT_BEGIN = 1'b1;

    localparam int EPOCH_BITS = 8;

    typedef struct packed {
        logic start;
        logic begin_list;
    } t_set_cmd;

    typedef struct packed {
        logic ready;
        logic done;
        logic dup;
        logic full;
    } t_set_rsp;

endpackage

>>> hdl/udd_edge_if.sv
`timescale 1ns / 1ps
// Valid/ready channel that carries one edge slot or a begin action per beat.
// Depends on nothing but its width parameter.
interface udd_edge_if #(
    parameter int VERTEX_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic                   edge_present;
    logic [VERTEX_BITS-1:0] vertex_a;
    logic [VERTEX_BITS-1:0] vertex_b;

    modport source (output valid, action, edge_present, vertex_a, vertex_b, input ready);
    modport sink (input valid, action, edge_present, vertex_a, vertex_b, output ready);
endinterface

>>> hdl/udd_result_if.sv
`timescale 1ns / 1ps
// Valid/ready channel that carries one detection result per beat.
// Depends on udd_pkg for the edge number width.
interface udd_result_if;
    import udd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     is_duplicate;
    logic [EDGE_NUM_BITS-1:0] edge_number;
    logic                     set_full;

    modport source (output valid, is_duplicate, edge_number, set_full, input ready);
    modport sink (input valid, is_duplicate, edge_number, set_full, output ready);
endinterface

>>> hdl/udd_hash_set.sv
`timescale 1ns / 1ps
// Open-addressed hash set of canonical vertex pairs in one synchronous memory.
// Entries carry an epoch tag so a begin empties the set; depends on udd_pkg.
module udd_hash_set #(
    parameter int VERTEX_BITS = 16,
    parameter int SET_ENTRIES = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  udd_pkg::t_set_cmd        i_cmd,
    input  logic [2*VERTEX_BITS-1:0] i_key,
    output udd_pkg::t_set_rsp        o_rsp
);
    import udd_pkg::*;

    localparam int KEY_W  = 2 * VERTEX_BITS;
    localparam int IDX_W  = $clog2(SET_ENTRIES);
    localparam int CNT_W  = $clog2(SET_ENTRIES + 1);
    localparam int ENT_W  = EPOCH_BITS + KEY_W;
    localparam int NCHUNK = (KEY_W + IDX_W - 1) / IDX_W;
    localparam int FOLD_W = NCHUNK * IDX_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SET_ENTRIES - 1);
    localparam logic [IDX_W:0]   ENTRIES_X = (IDX_W+1)'(SET_ENTRIES);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_CMP   = 2'd3;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [ENT_W-1:0]      r_pair_mem [SET_ENTRIES];
    logic [ENT_W-1:0]      r_rd_data;
    logic [KEY_W-1:0]      r_key;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_probes;
    logic [CNT_W-1:0]      r_count;
    logic [EPOCH_BITS-1:0] r_epoch;
    logic [IDX_W-1:0]      r_clr_idx;
    logic                  r_clr_reply;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENT_W-1:0]      wr_data;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      idx_next;
    logic [EPOCH_BITS-1:0] ent_tag;
    logic [KEY_W-1:0]      ent_key;
    logic                  ent_live;
    logic                  ent_hit;
    logic                  probe_last;
    logic                  insert;

    function automatic logic [IDX_W-1:0] f_hash(input logic [KEY_W-1:0] key);
        logic [FOLD_W-1:0] wide;
        logic [IDX_W-1:0]  h;
        logic [IDX_W:0]    ext;
        wide = FOLD_W'(key);
        h = '0;
        for (int i = 0; i < NCHUNK; i++) begin
            h = h ^ wide[i*IDX_W +: IDX_W];
        end
        ext = {1'b0, h};
        if (ext >= ENTRIES_X) begin
            ext = ext - ENTRIES_X;
        end
        return ext[IDX_W-1:0];
    endfunction

    assign ent_tag    = r_rd_data[ENT_W-1 -: EPOCH_BITS];
    assign ent_key    = r_rd_data[KEY_W-1:0];
    assign ent_live   = (ent_tag == r_epoch);
    assign ent_hit    = ent_live && (ent_key == r_key);
    assign idx_next   = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    assign probe_last = (r_probes == LAST_IDX);
    assign insert     = (r_state == S_CMP) && !ent_live;

    always_comb begin
        n_state     = r_state;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = {r_epoch, r_key};
        rd_addr     = r_idx;
        o_rsp       = '0;
        o_rsp.ready = (r_state == S_IDLE);
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_idx;
                wr_data = '0;
                if (r_clr_idx == LAST_IDX) begin
                    n_state    = S_IDLE;
                    o_rsp.done = r_clr_reply;
                end
            end
            S_IDLE: begin
                if (i_cmd.start) begin
                    if (i_cmd.begin_list) begin
                        if (r_epoch == '1) begin
                            n_state = S_CLEAR;
                        end else begin
                            o_rsp.done = 1'b1;
                        end
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                rd_addr = idx_next;
                if (ent_hit) begin
                    o_rsp.done = 1'b1;
                    o_rsp.dup  = 1'b1;
                    n_state    = S_IDLE;
                end else if (!ent_live) begin
                    wr_en      = 1'b1;
                    o_rsp.done = 1'b1;
                    n_state    = S_IDLE;
                end else if (probe_last) begin
                    o_rsp.done = 1'b1;
                    o_rsp.full = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_clr_reply <= 1'b0;
            r_epoch     <= '0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLEAR: begin
                    if (r_clr_idx == LAST_IDX) begin
                        r_clr_idx   <= '0;
                        r_clr_reply <= 1'b0;
                        r_epoch     <= EPOCH_BITS'(1);
                        r_count     <= '0;
                    end else begin
                        r_clr_idx <= r_clr_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_cmd.start && i_cmd.begin_list) begin
                        r_count <= '0;
                        if (r_epoch == '1) begin
                            r_clr_reply <= 1'b1;
                        end else begin
                            r_epoch <= r_epoch + 1'b1;
                        end
                    end
                end
                S_CMP: begin
                    if (insert) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd.start) begin
            r_key    <= i_key;
            r_idx    <= f_hash(i_key);
            r_probes <= '0;
        end else if (r_state == S_CMP) begin
            r_idx    <= idx_next;
            r_probes <= r_probes + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pair_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_pair_mem[rd_addr];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SET_ENTRIES))
        else $error("stored pair count exceeds the set size");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        insert |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not advance the stored pair count");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> r_state == S_IDLE)
        else $error("set command issued while the set is busy");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (r_epoch != '0))
        else $error("cleared tag value in use as the live epoch");

endmodule

>>> hdl/undirected_edge_duplicate_detector.sv
`timescale 1ns / 1ps
// Top level of the undirected edge duplicate detector: handshakes, edge counter and result register.
// Depends on udd_pkg, udd_edge_if, udd_result_if and udd_hash_set.
//
//  Channel    Dir  Beat carries
//  i_edge     in   action, edge_present, vertex_a, vertex_b
//  o_result   out  is_duplicate, edge_number, set_full
//
// An empty slot or a begin passes from the pending register into the result register after it is
// accepted. A present edge goes through the hash set's read and compare states first, one probe
// of the hash set memory per compare, up to SET_ENTRIES probes when the set is full. After reset,
// and on every 255th begin, a clearing pass sweeps the memory while i_edge.ready stays low. One
// edge is in work at a time; a result waiting in the output register does not stall the next
// edge, but a second finished result holds i_edge.ready low until the first one leaves.
module undirected_edge_duplicate_detector #(
    parameter int VERTEX_BITS = 16,
    parameter int SET_ENTRIES = 1024
) (
    input logic          i_clk,
    input logic          i_rst_n,
    udd_edge_if.sink     i_edge,
    udd_result_if.source o_result
);
    import udd_pkg::*;

    logic [EDGE_NUM_BITS-1:0] r_edge_cnt;
    logic [EDGE_NUM_BITS-1:0] n_edge_cnt;
    logic                     r_busy;
    logic                     r_pend_valid;
    logic                     r_pend_dup;
    logic                     r_pend_full;
    logic [EDGE_NUM_BITS-1:0] r_pend_num;
    logic                     r_out_valid;
    logic                     r_out_dup;
    logic                     r_out_full;
    logic [EDGE_NUM_BITS-1:0] r_out_num;

    logic                     acc;
    logic                     is_begin;
    logic                     skip_set;
    logic                     move_out;
    logic [VERTEX_BITS-1:0]   v_lo;
    logic [VERTEX_BITS-1:0]   v_hi;
    t_set_cmd                 set_cmd;
    t_set_rsp                 set_rsp;

    assign i_edge.ready = !r_busy && set_rsp.ready;
    assign acc          = i_edge.valid && i_edge.ready;
    assign is_begin     = (i_edge.action == ACT_BEGIN);
    assign skip_set     = !is_begin && !i_edge.edge_present;
    assign move_out     = r_pend_valid && (!r_out_valid || o_result.ready);

    assign n_edge_cnt = (r_edge_cnt == EDGE_NUM_MAX) ? r_edge_cnt : r_edge_cnt + 1'b1;

    assign v_lo = (i_edge.vertex_a < i_edge.vertex_b) ? i_edge.vertex_a : i_edge.vertex_b;
    assign v_hi = (i_edge.vertex_a < i_edge.vertex_b) ? i_edge.vertex_b : i_edge.vertex_a;

    assign set_cmd.start      = acc && !skip_set;
    assign set_cmd.begin_list = is_begin;

    udd_hash_set #(
        .VERTEX_BITS(VERTEX_BITS),
        .SET_ENTRIES(SET_ENTRIES)
    ) u_set (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (set_cmd),
        .i_key  ({v_lo, v_hi}),
        .o_rsp  (set_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_cnt   <= '0;
            r_busy       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (acc) begin
                r_busy     <= 1'b1;
                r_edge_cnt <= is_begin ? '0 : n_edge_cnt;
            end else if (move_out) begin
                r_busy <= 1'b0;
            end
            if (set_rsp.done || (acc && skip_set)) begin
                r_pend_valid <= 1'b1;
            end else if (move_out) begin
                r_pend_valid <= 1'b0;
            end
            if (move_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pend_num <= is_begin ? '0 : n_edge_cnt;
        end
        if (set_rsp.done) begin
            r_pend_dup  <= set_rsp.dup;
            r_pend_full <= set_rsp.full;
        end else if (acc && skip_set) begin
            r_pend_dup  <= 1'b0;
            r_pend_full <= 1'b0;
        end
        if (move_out) begin
            r_out_dup  <= r_pend_dup;
            r_out_full <= r_pend_full;
            r_out_num  <= r_pend_num;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.is_duplicate = r_out_dup;
    assign o_result.edge_number  = r_out_num;
    assign o_result.set_full     = r_out_full;

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_busy)
        else $error("pending result without an edge in work");

    a_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        set_rsp.done |-> (r_busy || acc) && !r_pend_valid)
        else $error("set answered with no edge waiting for it");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_busy || r_pend_valid || r_out_valid)
        else $error("accepted beat left no trace");

endmodule
